>>> design/fla_pkg.sv
// Shared constants and cell control types for the free-list extent allocator.
package fla_pkg;
  localparam int unsigned MAX_EXTENTS  = 16;
  localparam int unsigned MAX_BLOCKS   = 16;
  localparam int unsigned EXT_IDX_W    = $clog2(MAX_EXTENTS);
  localparam int unsigned BLK_IDX_W    = $clog2(MAX_BLOCKS);
  localparam int unsigned EXT_CNT_W    = $clog2(MAX_EXTENTS + 1);
  localparam logic [16:0] REGION_BYTES = 17'd65536;
  localparam logic [16:0] MIN_REGION   = 17'd64;
  localparam logic [16:0] HEADER_BYTES = 17'd16;
  localparam logic [16:0] NODE_BYTES   = 17'd16;
  localparam logic [12:0] MIN_ALIGN    = 13'd8;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FIT  = 3'd1;
  localparam logic [2:0] ST_BAD_REQ = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_REGION_SIZE = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_NEXT,
    CELL_TAKE_PREV
  } cell_op_t;

  // Row-wide command: optional load of one cell plus an optional shift.
  typedef struct packed {
    logic                 load_en;
    logic [EXT_IDX_W-1:0] tgt;
    logic [15:0]          ld_start;
    logic [16:0]          ld_len;
    logic                 shl;
    logic                 shr;
    logic [EXT_IDX_W-1:0] from;
  } row_ctl_t;
endpackage

>>> design/fla_ext_cell.sv
// One extent cell: holds a start and a length, loads or takes a neighbour's pair.
module fla_ext_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  fla_pkg::cell_op_t op,
  input  logic [15:0]     ld_start,
  input  logic [16:0]     ld_len,
  input  logic [15:0]     prev_start,
  input  logic [16:0]     prev_len,
  input  logic [15:0]     next_start,
  input  logic [16:0]     next_len,
  output logic [15:0]     start,
  output logic [16:0]     len
);
  import fla_pkg::*;

  logic [15:0] start_r;
  logic [16:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= REGION_BYTES;
    end else begin
      case (op)
        CELL_LOAD:      begin start_r <= ld_start;   len_r <= ld_len;   end
        CELL_TAKE_NEXT: begin start_r <= next_start; len_r <= next_len; end
        CELL_TAKE_PREV: begin start_r <= prev_start; len_r <= prev_len; end
        default:        begin start_r <= start_r;    len_r <= len_r;    end
      endcase
    end
  end

  assign start = start_r;
  assign len   = len_r;
endmodule

>>> design/fla_ext_row.sv
// Row of extent cells; decodes the row command into one operation per cell.
module fla_ext_row (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  fla_pkg::row_ctl_t                           ctl,
  output logic [fla_pkg::MAX_EXTENTS-1:0][15:0]       starts,
  output logic [fla_pkg::MAX_EXTENTS-1:0][16:0]       lens
);
  import fla_pkg::*;

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    cell_op_t    op;
    logic [15:0] ps, ns;
    logic [16:0] pl, nl;

    always_comb begin
      op = CELL_HOLD;
      if (ctl.load_en && ctl.tgt == EXT_IDX_W'(i)) begin
        op = CELL_LOAD;
      end else if (ctl.shl && EXT_IDX_W'(i) >= ctl.from && i < MAX_EXTENTS - 1) begin
        op = CELL_TAKE_NEXT;
      end else if (ctl.shr && EXT_IDX_W'(i) > ctl.from) begin
        op = CELL_TAKE_PREV;
      end
    end

    assign ps = starts[(i == 0) ? 0 : i - 1];
    assign pl = lens[(i == 0) ? 0 : i - 1];
    assign ns = starts[(i == MAX_EXTENTS - 1) ? i : i + 1];
    assign nl = lens[(i == MAX_EXTENTS - 1) ? i : i + 1];

    fla_ext_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .ld_start  (ctl.ld_start),
      .ld_len    (ctl.ld_len),
      .prev_start(ps),
      .prev_len  (pl),
      .next_start(ns),
      .next_len  (nl),
      .start     (starts[i]),
      .len       (lens[i])
    );
  end
endmodule

>>> design/free_list_extent_allocator.sv
// Top level of the free-list extent allocator: request sequencer, block records, counters.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  in_      | slave     | request: func, request_size, align_bytes, free_offset
//  out_     | master    | result: status, data_offset, used_bytes, peak_bytes
//  cfg_     | write     | fit_policy (index 0), region_size (index 1)
//
// An allocate walks the extent row one extent per cycle (up to 16 extents) in S_SCAN_A,
// then updates in S_APPLY_A; best fit always scans past the last extent. A free walks
// S_SCAN_F up to the insertion point, then merges in S_APPLY_F; reset-region and rejected
// requests go straight to the result stage S_RESP.
// Reset (rst_n low, synchronous) gives one extent of the full region, no blocks.
// A result waits in the output register; the next request is taken meanwhile and
// stalls only at its own result stage while out_tready is low.
module free_list_extent_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[1:0], request_size[18:2], align_bytes[31:19],
                                  // free_offset[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[2:0], data_offset[18:3], used_bytes[35:19],
                                  // peak_bytes[52:36], zero[55:53]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);
  import fla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_A, S_APPLY_A, S_SCAN_F, S_APPLY_F, S_RESP
  } state_t;

  state_t state_r;

  // configuration
  logic        fit_policy_r;
  logic [16:0] region_size_r;

  // request fields
  logic [1:0]  in_func;
  logic [16:0] in_size;
  logic [12:0] in_align;
  logic [15:0] in_off;
  assign in_func  = in_tdata[1:0];
  assign in_size  = in_tdata[18:2];
  assign in_align = in_tdata[31:19];
  assign in_off   = in_tdata[47:32];

  logic [16:0] size_r;
  logic [12:0] align_r;

  // extent row
  row_ctl_t                          ctl;
  logic [MAX_EXTENTS-1:0][15:0]      ext_start;
  logic [MAX_EXTENTS-1:0][16:0]      ext_len;
  logic [EXT_CNT_W-1:0]              ext_count_r;

  fla_ext_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .starts(ext_start),
    .lens  (ext_len)
  );

  // block records
  logic [MAX_BLOCKS-1:0]        blk_valid_r;
  logic [15:0]                  blk_off_r [MAX_BLOCKS];
  logic [16:0]                  blk_len_r [MAX_BLOCKS];
  logic [15:0]                  blk_pad_r [MAX_BLOCKS];

  logic [16:0] used_r, peak_r;

  // scan state
  logic [EXT_CNT_W-1:0] idx_r;
  logic [BLK_IDX_W-1:0] slot_r;
  logic [EXT_IDX_W-1:0] best_r;
  logic [15:0]          best_pad_r;
  logic [16:0]          best_left_r;
  logic                 found_r;
  logic [15:0]          fs_r;
  logic [16:0]          fl_r;
  logic [EXT_IDX_W-1:0] pos_r;
  logic                 pos_end_r;
  logic [2:0]           status_r;
  logic [15:0]          data_r;

  logic        out_valid_r;
  logic [55:0] out_data_r;

  // free slot and offset match over the block records
  logic                 slot_found, blk_hit;
  logic [BLK_IDX_W-1:0] slot_idx, hit_idx;
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    blk_hit    = 1'b0;
    hit_idx    = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if (!blk_valid_r[b]) begin
        slot_found = 1'b1;
        slot_idx   = BLK_IDX_W'(b);
      end
      if (blk_valid_r[b] && blk_off_r[b] == in_off) begin
        blk_hit = 1'b1;
        hit_idx = BLK_IDX_W'(b);
      end
    end
  end

  logic bad_req;
  assign bad_req = (in_align < MIN_ALIGN) || ((in_align & (in_align - 13'd1)) != 13'd0)
                   || (in_size < NODE_BYTES);

  // extent under the scan pointer: padding, need and leftover
  logic [EXT_IDX_W-1:0] sidx;
  logic [15:0] cur_start;
  logic [16:0] cur_len;
  logic [16:0] hdr_base;
  logic [15:0] cur_pad;
  logic [17:0] cur_need;
  logic        cur_fits;
  logic [16:0] cur_left;
  logic        scan_end;
  assign sidx      = idx_r[EXT_IDX_W-1:0];
  assign scan_end  = (idx_r >= ext_count_r);
  assign cur_start = ext_start[sidx];
  assign cur_len   = ext_len[sidx];
  assign hdr_base  = {1'b0, cur_start} + HEADER_BYTES;
  assign cur_pad   = 16'((17'(~hdr_base + 17'd1) & {4'd0, align_r - 13'd1}) + HEADER_BYTES);
  assign cur_need  = {1'b0, size_r} + {2'b0, cur_pad};
  assign cur_fits  = {1'b0, cur_len} >= cur_need;
  assign cur_left  = 17'({1'b0, cur_len} - cur_need);

  // chosen extent for allocate
  logic [15:0] b_start;
  logic [16:0] b_len;
  logic [16:0] b_need;
  logic        b_split;
  assign b_start = ext_start[best_r];
  assign b_len   = ext_len[best_r];
  assign b_need  = 17'(size_r + {1'b0, best_pad_r});
  assign b_split = best_left_r > NODE_BYTES;

  // neighbours for free
  logic [EXT_IDX_W-1:0] pm1;
  logic [16:0]          prev_end, fs_end;
  logic                 prev_touch, next_touch, ins_full;
  assign pm1        = pos_r - EXT_IDX_W'(1);
  assign prev_end   = {1'b0, ext_start[pm1]} + ext_len[pm1];
  assign fs_end     = {1'b0, fs_r} + fl_r;
  assign prev_touch = (pos_end_r ? (ext_count_r != '0) : (pos_r != '0))
                      && prev_end == {1'b0, fs_r};
  assign next_touch = !pos_end_r && fs_end == {1'b0, ext_start[pos_r]};
  assign ins_full   = ext_count_r >= EXT_CNT_W'(MAX_EXTENTS);

  logic [16:0] clamp_r;
  assign clamp_r = (region_size_r < MIN_REGION) ? MIN_REGION :
                   (region_size_r > REGION_BYTES) ? REGION_BYTES : region_size_r;

  // insertion index: the extent count when the scan ran off the end, else the scan position
  logic [EXT_IDX_W-1:0] ins_idx;
  assign ins_idx = pos_end_r ? ext_count_r[EXT_IDX_W-1:0] : pos_r;

  logic accept;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // row command
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_func == FUNC_RESET) begin
          ctl.load_en = 1'b1;
          ctl.tgt     = '0;
          ctl.ld_len  = clamp_r;
        end
      end
      S_APPLY_A: begin
        if (found_r) begin
          if (b_split) begin
            ctl.load_en  = 1'b1;
            ctl.tgt      = best_r;
            ctl.ld_start = 16'({1'b0, b_start} + b_need);
            ctl.ld_len   = best_left_r;
          end else begin
            ctl.shl  = 1'b1;
            ctl.from = best_r;
          end
        end
      end
      S_APPLY_F: begin
        if (prev_touch && next_touch) begin
          ctl.load_en  = 1'b1;
          ctl.tgt      = pm1;
          ctl.ld_start = ext_start[pm1];
          ctl.ld_len   = 17'(ext_len[pm1] + fl_r + ext_len[pos_r]);
          ctl.shl      = 1'b1;
          ctl.from     = pos_r;
        end else if (prev_touch) begin
          ctl.load_en  = 1'b1;
          ctl.tgt      = pos_end_r ? ext_count_r[EXT_IDX_W-1:0] - EXT_IDX_W'(1) : pm1;
          ctl.ld_start = ext_start[ctl.tgt];
          ctl.ld_len   = 17'(ext_len[ctl.tgt] + fl_r);
        end else if (next_touch) begin
          ctl.load_en  = 1'b1;
          ctl.tgt      = pos_r;
          ctl.ld_start = fs_r;
          ctl.ld_len   = 17'(ext_len[pos_r] + fl_r);
        end else if (!ins_full) begin
          ctl.load_en  = 1'b1;
          ctl.tgt      = ins_idx;
          ctl.ld_start = fs_r;
          ctl.ld_len   = fl_r;
          ctl.shr      = !pos_end_r;
          ctl.from     = pos_r;
        end
      end
      default: ctl = '0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r  <= 1'b0;
      region_size_r <= REGION_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:  fit_policy_r  <= cfg_wdata[0];
        default:         region_size_r <= cfg_wdata;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ext_count_r <= EXT_CNT_W'(1);
      blk_valid_r <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless the result stage refills the register now
      if (out_valid_r && out_tready && state_r != S_RESP) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            size_r   <= in_size;
            align_r  <= in_align;
            data_r   <= '0;
            idx_r    <= '0;
            found_r  <= 1'b0;
            case (in_func)
              FUNC_ALLOC: begin
                if (bad_req) begin
                  status_r <= ST_BAD_REQ;
                  state_r  <= S_RESP;
                end else if (!slot_found) begin
                  status_r <= ST_FULL;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  slot_r   <= slot_idx;
                  state_r  <= S_SCAN_A;
                end
              end
              FUNC_FREE: begin
                if (!blk_hit) begin
                  status_r <= ST_UNKNOWN;
                  state_r  <= S_RESP;
                end else begin
                  status_r <= ST_OK;
                  slot_r   <= hit_idx;
                  fs_r     <= in_off - blk_pad_r[hit_idx];
                  fl_r     <= blk_len_r[hit_idx];
                  state_r  <= S_SCAN_F;
                end
              end
              FUNC_RESET: begin
                status_r    <= ST_OK;
                state_r     <= S_RESP;
                ext_count_r <= EXT_CNT_W'(1);
                blk_valid_r <= '0;
                used_r      <= '0;
                peak_r      <= '0;
              end
              default: begin
                status_r <= ST_BAD_REQ;
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN_A: begin
          // walk the row one extent a cycle; first fit stops at the first fit, best fit keeps the smallest leftover
          if (scan_end) begin
            state_r <= S_APPLY_A;
          end else begin
            if (cur_fits && (!found_r || cur_left < best_left_r)) begin
              found_r     <= 1'b1;
              best_r      <= sidx;
              best_pad_r  <= cur_pad;
              best_left_r <= cur_left;
            end
            if (cur_fits && !fit_policy_r) state_r <= S_APPLY_A;
            idx_r <= idx_r + EXT_CNT_W'(1);
          end
        end
        S_APPLY_A: begin
          if (!found_r) begin
            status_r <= ST_NO_FIT;
          end else begin
            data_r                <= b_start + best_pad_r;
            blk_valid_r[slot_r]   <= 1'b1;
            blk_off_r[slot_r]     <= b_start + best_pad_r;
            blk_pad_r[slot_r]     <= best_pad_r;
            if (b_split) begin
              blk_len_r[slot_r] <= b_need;
              used_r            <= used_r + b_need;
              if (used_r + b_need > peak_r) peak_r <= used_r + b_need;
            end else begin
              blk_len_r[slot_r] <= b_len;
              used_r            <= used_r + b_len;
              if (used_r + b_len > peak_r) peak_r <= used_r + b_len;
              ext_count_r       <= ext_count_r - EXT_CNT_W'(1);
            end
          end
          state_r <= S_RESP;
        end
        S_SCAN_F: begin
          // find the first extent that starts above the freed extent
          if (scan_end || {1'b0, cur_start} > {1'b0, fs_r}) begin
            pos_r     <= sidx;
            pos_end_r <= scan_end;
            state_r   <= S_APPLY_F;
          end else begin
            idx_r <= idx_r + EXT_CNT_W'(1);
          end
        end
        S_APPLY_F: begin
          if (!prev_touch && !next_touch && ins_full) begin
            status_r <= ST_FULL;
          end else begin
            blk_valid_r[slot_r] <= 1'b0;
            used_r              <= used_r - fl_r;
            if (prev_touch && next_touch) ext_count_r <= ext_count_r - EXT_CNT_W'(1);
            else if (!prev_touch && !next_touch) ext_count_r <= ext_count_r + EXT_CNT_W'(1);
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'd0, peak_r, used_r,
                            (status_r == ST_OK) ? data_r : 16'd0, status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
